// ===== rtl/ipv4f_pkg.sv =====
package ipv4f_pkg;

    // Number of interfaces that take part in the destination match.
    localparam int NUM_IFACES = 2;
    // Interfaces that own configuration registers; the rest stay unconfigured.
    localparam int CFG_IFACES = 2;
    localparam int IFACE_W    = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;

    localparam int CFG_INDEX_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IFACE0_ADDR = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IFACE0_MASK = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IFACE1_ADDR = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IFACE1_MASK = 8'd3;

    localparam logic [3:0]  IPV4_VERSION   = 4'd4;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [3:0]  MCAST_PREFIX   = 4'hE;
    localparam logic [15:0] FRAG_MASK      = 16'h3FFF;
    localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [5:0]  BYTE_COUNT_MAX = 6'd63;

    // Header byte positions.
    localparam logic [5:0] POS_LEN_HI   = 6'd2;
    localparam logic [5:0] POS_LEN_LO   = 6'd3;
    localparam logic [5:0] POS_FLAGS_HI = 6'd6;
    localparam logic [5:0] POS_FLAGS_LO = 6'd7;
    localparam logic [5:0] POS_PROTO    = 6'd9;
    localparam logic [5:0] POS_SRC      = 6'd12;
    localparam logic [5:0] POS_DST      = 6'd16;
    localparam logic [5:0] POS_HDR_END  = 6'd20;

    typedef enum logic [3:0] {
        VERDICT_UDP         = 4'd0,
        VERDICT_TCP         = 4'd1,
        VERDICT_BAD_VERSION = 4'd2,
        VERDICT_BAD_LENGTH  = 4'd3,
        VERDICT_BAD_CSUM    = 4'd4,
        VERDICT_BAD_SOURCE  = 4'd5,
        VERDICT_NOT_FOR_US  = 4'd6,
        VERDICT_FRAGMENT    = 4'd7,
        VERDICT_UNKNOWN     = 4'd8
    } verdict_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] mask;
    } iface_cfg_t;

endpackage

// ===== rtl/ipv4_receive_header_filter_top.sv =====
// IPv4 receive header filter.
//
// Packet bytes enter on the input channel one item per byte, starting at the
// first byte of the IP header; last_byte marks the final byte. The buffer
// lengths and the receiving interface are sampled with byte zero. On the last
// byte one verdict item leaves on the output channel with the matched
// interface and the protocol number; no other byte produces an output item.
//
// The input item is registered, then the header capture, the running ones'
// complement checksum and the verdict are worked out combinationally into the
// output register. out_valid rises once the last byte has passed from the input
// register into the output register, and one byte is taken in every cycle while in_ready is high.
//
// When the receiver stalls, a waiting verdict holds in the output register.
// Non-final bytes keep flowing; only a last byte that meets a full output
// register waits in the input register, and in_ready drops until the output
// is taken. The interface registers are written on the cfg channel, which is
// always ready. Reset clears the interface registers, the byte counter and
// both pipeline valids, so the first byte after reset is byte zero.
module ipv4_receive_header_filter_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] first_buffer_len,
    input  logic [15:0] total_avail_len,
    input  logic        rx_iface,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  verdict,
    output logic        matched_iface,
    output logic [7:0]  protocol_number
);

    localparam int NUM_IFACES = ipv4f_pkg::NUM_IFACES;
    localparam int CFG_IFACES = ipv4f_pkg::CFG_IFACES;
    localparam int IFACE_W    = ipv4f_pkg::IFACE_W;

    // Configuration registers.
    ipv4f_pkg::iface_cfg_t cfg_reg [CFG_IFACES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CFG_IFACES; k++)
            begin
                cfg_reg[k] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ipv4f_pkg::REG_IFACE0_ADDR: cfg_reg[0].addr <= cfg_data;
                ipv4f_pkg::REG_IFACE0_MASK: cfg_reg[0].mask <= cfg_data;
                ipv4f_pkg::REG_IFACE1_ADDR: cfg_reg[1].addr <= cfg_data;
                ipv4f_pkg::REG_IFACE1_MASK: cfg_reg[1].mask <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register stage.
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic [15:0] s1_buf_len_reg;
    logic [15:0] s1_avail_len_reg;
    logic        s1_rx_reg;
    logic        s1_go;
    logic        out_valid_reg;

    // The input stage moves on unless it holds a last byte and the output is full.
    assign s1_go    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg      <= data_byte;
            s1_last_reg      <= last_byte;
            s1_buf_len_reg   <= first_buffer_len;
            s1_avail_len_reg <= total_avail_len;
            s1_rx_reg        <= rx_iface;
        end
    end

    // Per-packet header state.
    logic [5:0]  byte_count_reg,   byte_count_next;
    logic [7:0]  version_ihl_reg,  version_ihl_next;
    logic [15:0] total_len_reg,    total_len_next;
    logic [15:0] flags_offset_reg, flags_offset_next;
    logic [7:0]  proto_reg,        proto_next;
    logic [31:0] source_addr_reg,  source_addr_next;
    logic [31:0] dst_ip_reg,       dst_ip_next;
    logic [15:0] checksum_reg,     checksum_next;
    logic [7:0]  odd_byte_reg,     odd_byte_next;
    logic [15:0] buf_len_reg,      buf_len_next;
    logic [15:0] avail_len_reg,    avail_len_next;
    logic        rx_iface_reg,     rx_iface_next;

    logic [5:0]  idx;
    logic        first;
    logic [3:0]  ihl;
    logic [5:0]  hlen;
    logic [16:0] csum_sum;

    assign idx   = byte_count_reg;
    assign first = (idx == 6'd0);

    always_comb
    begin
        // Byte zero starts a packet: loads version/IHL, lengths, interface; clears the rest.
        version_ihl_next  = first ? s1_byte_reg      : version_ihl_reg;
        total_len_next    = first ? 16'd0            : total_len_reg;
        flags_offset_next = first ? 16'd0            : flags_offset_reg;
        proto_next        = first ? 8'd0             : proto_reg;
        source_addr_next  = first ? 32'd0            : source_addr_reg;
        dst_ip_next       = first ? 32'd0            : dst_ip_reg;
        checksum_next     = first ? 16'd0            : checksum_reg;
        odd_byte_next     = first ? 8'd0             : odd_byte_reg;
        buf_len_next      = first ? s1_buf_len_reg   : buf_len_reg;
        avail_len_next    = first ? s1_avail_len_reg : avail_len_reg;
        rx_iface_next     = first ? s1_rx_reg        : rx_iface_reg;

        case (idx)
            ipv4f_pkg::POS_LEN_HI:   total_len_next[15:8]    = s1_byte_reg;
            ipv4f_pkg::POS_LEN_LO:   total_len_next[7:0]     = s1_byte_reg;
            ipv4f_pkg::POS_FLAGS_HI: flags_offset_next[15:8] = s1_byte_reg;
            ipv4f_pkg::POS_FLAGS_LO: flags_offset_next[7:0]  = s1_byte_reg;
            ipv4f_pkg::POS_PROTO:    proto_next              = s1_byte_reg;
            default:
            begin
                if (idx >= ipv4f_pkg::POS_SRC && idx < ipv4f_pkg::POS_DST)
                begin
                    source_addr_next[8*(3-idx[1:0]) +: 8] = s1_byte_reg;
                end
                else if (idx >= ipv4f_pkg::POS_DST && idx < ipv4f_pkg::POS_HDR_END)
                begin
                    dst_ip_next[8*(3-idx[1:0]) +: 8] = s1_byte_reg;
                end
            end
        endcase

        ihl  = version_ihl_next[3:0];
        hlen = {ihl, 2'b00};

        // Header bytes pair up into 16-bit words for the end-around carry sum.
        csum_sum = {1'b0, checksum_next} + {1'b0, odd_byte_next, s1_byte_reg};
        if (idx < hlen)
        begin
            if (!idx[0])
            begin
                odd_byte_next = s1_byte_reg;
            end
            else
            begin
                checksum_next = csum_sum[15:0] + {15'd0, csum_sum[16]};
            end
        end

        if (s1_last_reg)
        begin
            byte_count_next = 6'd0;
        end
        else if (idx != ipv4f_pkg::BYTE_COUNT_MAX)
        begin
            byte_count_next = idx + 6'd1;
        end
        else
        begin
            byte_count_next = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            version_ihl_reg  <= '0;
            total_len_reg    <= '0;
            flags_offset_reg <= '0;
            proto_reg        <= '0;
            source_addr_reg  <= '0;
            dst_ip_reg       <= '0;
            checksum_reg     <= '0;
            odd_byte_reg     <= '0;
            buf_len_reg      <= '0;
            avail_len_reg    <= '0;
            rx_iface_reg     <= '0;
        end
        else if (s1_go)
        begin
            byte_count_reg   <= byte_count_next;
            version_ihl_reg  <= version_ihl_next;
            total_len_reg    <= total_len_next;
            flags_offset_reg <= flags_offset_next;
            proto_reg        <= proto_next;
            source_addr_reg  <= source_addr_next;
            dst_ip_reg       <= dst_ip_next;
            checksum_reg     <= checksum_next;
            odd_byte_reg     <= odd_byte_next;
            buf_len_reg      <= buf_len_next;
            avail_len_reg    <= avail_len_next;
            rx_iface_reg     <= rx_iface_next;
        end
    end

    // Interface matching, one matcher per interface. Interfaces without
    // registers read as unconfigured.
    logic [NUM_IFACES-1:0] dest_accept;
    logic [NUM_IFACES-1:0] source_bcast;

    for (genvar g = 0; g < NUM_IFACES; g++)
    begin : g_iface
        ipv4f_pkg::iface_cfg_t iface_cfg;

        if (g < CFG_IFACES)
        begin : g_cfg
            assign iface_cfg = cfg_reg[g];
        end
        else
        begin : g_none
            assign iface_cfg = '0;
        end

        ipv4f_iface_match u_match (
            .iface        (iface_cfg),
            .dst_ip       (dst_ip_next),
            .source_addr  (source_addr_next),
            .dest_accept  (dest_accept[g]),
            .source_bcast (source_bcast[g])
        );
    end

    // Verdict for the packet ending with this byte.
    logic [IFACE_W-1:0]    rx_sel;
    logic [NUM_IFACES-1:0] rx_onehot;
    logic                  rx_accept;
    logic                  found;
    logic [IFACE_W-1:0]    matched;
    logic                  length_bad;
    ipv4f_pkg::verdict_t   verdict_next;

    always_comb
    begin
        // A receiving interface out of range falls back to interface 0.
        rx_sel = ({31'd0, rx_iface_next} < NUM_IFACES) ? IFACE_W'(rx_iface_next) : '0;
        for (int k = 0; k < NUM_IFACES; k++)
        begin
            rx_onehot[k] = (rx_sel == IFACE_W'(k));
        end
        rx_accept = |(dest_accept & rx_onehot);

        // The receiving interface wins; otherwise the lowest accepting one.
        found   = rx_accept;
        matched = rx_sel;
        for (int k = NUM_IFACES - 1; k >= 0; k--)
        begin
            if (!rx_accept && dest_accept[k])
            begin
                found   = 1'b1;
                matched = IFACE_W'(k);
            end
        end

        length_bad = (version_ihl_next[3:0] < ipv4f_pkg::MIN_IHL) ||
                     ({10'd0, hlen} > buf_len_next) ||
                     (total_len_next > avail_len_next) ||
                     (({1'b0, idx} + 7'd1) < {1'b0, hlen});

        if (version_ihl_next[7:4] != ipv4f_pkg::IPV4_VERSION)
        begin
            verdict_next = ipv4f_pkg::VERDICT_BAD_VERSION;
        end
        else if (length_bad)
        begin
            verdict_next = ipv4f_pkg::VERDICT_BAD_LENGTH;
        end
        else if (checksum_next != ipv4f_pkg::CSUM_GOOD)
        begin
            verdict_next = ipv4f_pkg::VERDICT_BAD_CSUM;
        end
        else if ((|(source_bcast & rx_onehot)) ||
                 (source_addr_next[31:28] == ipv4f_pkg::MCAST_PREFIX))
        begin
            verdict_next = ipv4f_pkg::VERDICT_BAD_SOURCE;
        end
        else if (!found)
        begin
            verdict_next = ipv4f_pkg::VERDICT_NOT_FOR_US;
        end
        else if ((flags_offset_next & ipv4f_pkg::FRAG_MASK) != 16'd0)
        begin
            verdict_next = ipv4f_pkg::VERDICT_FRAGMENT;
        end
        else if (proto_next == ipv4f_pkg::PROTO_UDP)
        begin
            verdict_next = ipv4f_pkg::VERDICT_UDP;
        end
        else if (proto_next == ipv4f_pkg::PROTO_TCP)
        begin
            verdict_next = ipv4f_pkg::VERDICT_TCP;
        end
        else
        begin
            verdict_next = ipv4f_pkg::VERDICT_UNKNOWN;
        end
    end

    // The matched interface is reported only when the destination check found a match.
    logic                match_ran;
    ipv4f_pkg::verdict_t verdict_reg;
    logic                matched_reg;
    logic [7:0]          protocol_reg;

    assign match_ran = (verdict_next == ipv4f_pkg::VERDICT_UDP) ||
                       (verdict_next == ipv4f_pkg::VERDICT_TCP) ||
                       (verdict_next == ipv4f_pkg::VERDICT_FRAGMENT) ||
                       (verdict_next == ipv4f_pkg::VERDICT_UNKNOWN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            verdict_reg  <= verdict_next;
            matched_reg  <= match_ran && matched[0];
            protocol_reg <= proto_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign matched_iface   = matched_reg;
    assign protocol_number = protocol_reg;

    // The next packet always starts at byte zero.
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_last_reg |=> byte_count_reg == 6'd0)
        else $error("byte counter did not restart after the last byte");

    // Backpressure only comes from a last byte meeting a full output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && s1_last_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a waiting verdict");

    // Rejections up to and including the destination check report interface zero.
    a_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == ipv4f_pkg::VERDICT_BAD_VERSION ||
                      verdict == ipv4f_pkg::VERDICT_BAD_LENGTH ||
                      verdict == ipv4f_pkg::VERDICT_BAD_CSUM ||
                      verdict == ipv4f_pkg::VERDICT_BAD_SOURCE ||
                      verdict == ipv4f_pkg::VERDICT_NOT_FOR_US) |-> !matched_iface)
        else $error("matched interface set on an early rejection");

endmodule

// ===== rtl/ipv4f_iface_match.sv =====
module ipv4f_iface_match (
    input  ipv4f_pkg::iface_cfg_t iface,
    input  logic [31:0]           dst_ip,
    input  logic [31:0]           source_addr,
    output logic                  dest_accept,
    output logic                  source_bcast
);

    // All ones or zero is always broadcast; otherwise a subnet broadcast is an
    // address on the subnet with all host bits set that is not our own address.
    function automatic logic is_bcast(input logic [31:0] a, input ipv4f_pkg::iface_cfg_t c);
        logic result;
        begin
            if (a == 32'hFFFF_FFFF || a == 32'd0)
            begin
                result = 1'b1;
            end
            else if (a == c.addr)
            begin
                result = 1'b0;
            end
            else
            begin
                result = ((a & c.mask) == (c.addr & c.mask)) && ((a | c.mask) == 32'hFFFF_FFFF);
            end
            return result;
        end
    endfunction

    assign dest_accept  = (iface.addr != 32'd0) &&
                          ((dst_ip == iface.addr) || is_bcast(dst_ip, iface));
    assign source_bcast = is_bcast(source_addr, iface);

endmodule
